/* src/dtpm_pkg.sv */
// Shared constants and types for the dual text progress matcher.
package dtpm_pkg;

    localparam int TEXT_DEPTH = 1024;
    localparam int IDX_W      = $clog2(TEXT_DEPTH);
    localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);
    localparam int RAM_AW     = IDX_W + 1;
    localparam int CHAR_W     = 16;
    localparam int CNT_W      = 16;

    typedef enum logic [1:0] {
        FUNC_CLEAR       = 2'd0,
        FUNC_APPEND_SRC  = 2'd1,
        FUNC_APPEND_TRN  = 2'd2,
        FUNC_TEST        = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MATCH_NONE    = 2'd0,
        MATCH_ADVANCE = 2'd1,
        MATCH_REPEAT  = 2'd2
    } match_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TRY  = 6'b000010,
        S_REP  = 6'b000100,
        S_SCAN = 6'b001000,
        S_CMP  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    // Text select bit: upper address bit of the shared text memory
    localparam logic SEL_SRC = 1'b0;
    localparam logic SEL_TRN = 1'b1;

endpackage

/* src/dtpm_text_ram.sv */
// Single-port-write, single-port-read text memory holding both texts.
module dtpm_text_ram
    import dtpm_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [RAM_AW-1:0] waddr,
    input  logic [CHAR_W-1:0] wdata,
    input  logic [RAM_AW-1:0] raddr,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [2*TEXT_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/dual_text_progress_matcher_core.sv */
// Top level of the dual text progress matcher: sequencer, state and result register.
// One transaction at a time: s_ready is high only while the sequencer is idle. Clear
// and append are done in the accepting cycle, then S_DONE loads the result register
// once it is free. A test also passes through the accepting cycle and S_DONE, and adds
// for each text tried a setup step (S_TRY), a repeat check (S_REP) when the previous
// position lies inside that text, a read step (S_SCAN) and a compare step (S_CMP)
// per scanned character on the single read port of the shared text memory, and a
// final S_SCAN step when the scan runs off the end of the text; at most two texts are
// tried. Both texts live in one memory, source in the lower half. Text contents
// are not cleared: the stored lengths bound every read. No clearing pass is needed
// after reset. The input is accepted while a previous result still waits in the
// output register.
module dual_text_progress_matcher_core
    import dtpm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [CHAR_W-1:0] s_char_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_match_code,
    output logic [CNT_W-1:0]  m_hit_count,
    output logic [CNT_W-1:0]  m_miss_count,
    output logic [LEN_W-1:0]  m_position,
    output logic              m_translated_mode
);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  src_len_reg, src_len_next;
    logic [LEN_W-1:0]  trn_len_reg, trn_len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  hits_reg, hits_next;
    logic [CNT_W-1:0]  misses_reg, misses_next;
    logic              flag_reg, flag_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              sel_reg, sel_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    match_t            code_reg, code_next;

    logic              m_valid_reg;
    logic [1:0]        m_match_code_reg;
    logic [CNT_W-1:0]  m_hit_count_reg;
    logic [CNT_W-1:0]  m_miss_count_reg;
    logic [LEN_W-1:0]  m_position_reg;
    logic              m_translated_mode_reg;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RAM_AW-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic              accept;
    logic              out_free;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  pos_m1;
    logic              char_hit;
    func_t             func;

    assign func     = func_t'(s_func);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cur_len  = (sel_reg == SEL_TRN) ? trn_len_reg : src_len_reg;
    assign pos_m1   = pos_reg - LEN_W'(1);
    // Shared compare unit for both repeat check and scan
    assign char_hit = (ram_rdata == ch_reg);

    assign ram_raddr = (state_reg == S_TRY) ? {sel_reg, pos_m1[IDX_W-1:0]}
                                            : {sel_reg, idx_reg[IDX_W-1:0]};

    dtpm_text_ram u_text_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_char_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        src_len_next = src_len_reg;
        trn_len_next = trn_len_reg;
        pos_next     = pos_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        flag_next    = flag_reg;
        ch_next      = ch_reg;
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        code_next    = code_reg;
        ram_we       = 1'b0;
        ram_waddr    = {SEL_SRC, src_len_reg[IDX_W-1:0]};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ch_next    = s_char_value;
                    code_next  = MATCH_NONE;
                    state_next = S_DONE;
                    unique case (func)
                        FUNC_CLEAR: begin
                            src_len_next = '0;
                            trn_len_next = '0;
                            pos_next     = '0;
                            hits_next    = '0;
                            misses_next  = '0;
                            flag_next    = 1'b0;
                        end
                        FUNC_APPEND_SRC: begin
                            if (s_char_value != '0 && src_len_reg < LEN_W'(TEXT_DEPTH)) begin
                                ram_we       = 1'b1;
                                ram_waddr    = {SEL_SRC, src_len_reg[IDX_W-1:0]};
                                src_len_next = src_len_reg + LEN_W'(1);
                            end
                        end
                        FUNC_APPEND_TRN: begin
                            if (s_char_value != '0 && trn_len_reg < LEN_W'(TEXT_DEPTH)) begin
                                ram_we       = 1'b1;
                                ram_waddr    = {SEL_TRN, trn_len_reg[IDX_W-1:0]};
                                trn_len_next = trn_len_reg + LEN_W'(1);
                            end
                        end
                        FUNC_TEST: begin
                            if (s_char_value != '0) begin
                                sel_next   = flag_reg ? SEL_TRN : SEL_SRC;
                                state_next = S_TRY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TRY: begin
                // Repeat check reads the character just before the position
                idx_next = pos_reg;
                if (pos_reg != '0 && pos_m1 < cur_len) begin
                    state_next = S_REP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_REP: begin
                if (char_hit) begin
                    code_next  = MATCH_REPEAT;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg < cur_len) begin
                    state_next = S_CMP;
                end else if (sel_reg == SEL_SRC) begin
                    // fall back to the translated text
                    sel_next   = SEL_TRN;
                    state_next = S_TRY;
                end else begin
                    hits_next = '0;
                    if (misses_reg != '1) begin
                        misses_next = misses_reg + CNT_W'(1);
                    end
                    code_next  = MATCH_NONE;
                    state_next = S_DONE;
                end
            end
            S_CMP: begin
                if (char_hit) begin
                    pos_next = idx_reg + LEN_W'(1);
                    if (hits_reg != '1) begin
                        hits_next = hits_reg + CNT_W'(1);
                    end
                    misses_next = '0;
                    if (sel_reg == SEL_TRN) begin
                        flag_next = 1'b1;
                    end
                    code_next  = MATCH_ADVANCE;
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            src_len_reg <= '0;
            trn_len_reg <= '0;
            pos_reg     <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            src_len_reg <= src_len_next;
            trn_len_reg <= trn_len_next;
            pos_reg     <= pos_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            flag_reg    <= flag_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        sel_reg  <= sel_next;
        idx_reg  <= idx_next;
        code_reg <= code_next;
        if (state_reg == S_DONE && out_free) begin
            m_match_code_reg      <= code_reg;
            m_hit_count_reg       <= hits_reg;
            m_miss_count_reg      <= misses_reg;
            m_position_reg        <= pos_reg;
            m_translated_mode_reg <= flag_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_match_code      = m_match_code_reg;
    assign m_hit_count       = m_hit_count_reg;
    assign m_miss_count      = m_miss_count_reg;
    assign m_position        = m_position_reg;
    assign m_translated_mode = m_translated_mode_reg;

endmodule
